@@ hdl/ptzd_pkg.sv @@
// Shared types and constants for the PTZ command frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package ptzd_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam int FRAME_LEN = 7;
	localparam int QUEUE_DEPTH = 4;

	localparam int POS_W = 3;

	// Frame positions, counted as bytes of the current frame seen so far.
	localparam logic [POS_W-1:0] POS_IDLE = 3'd0;
	localparam logic [POS_W-1:0] POS_ADDR = 3'd1;
	localparam logic [POS_W-1:0] POS_CMD1 = 3'd2;
	localparam logic [POS_W-1:0] POS_CMD2 = 3'd3;
	localparam logic [POS_W-1:0] POS_PAN = 3'd4;
	localparam logic [POS_W-1:0] POS_TILT = 3'd5;
	localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_LEN - 1);

	// Direction bits of command byte 2.
	localparam int CMD2_RIGHT_BIT = 1;
	localparam int CMD2_LEFT_BIT = 2;
	localparam int CMD2_UP_BIT = 3;
	localparam int CMD2_DOWN_BIT = 4;

	typedef enum logic [2:0] {
		EV_STOP = 3'd0,
		EV_RIGHT = 3'd1,
		EV_LEFT = 3'd2,
		EV_UP = 3'd3,
		EV_DOWN = 3'd4,
		EV_ERROR = 3'd5
	} ptzd_event_t;

	// A completed frame as handed from the front end to the back end.
	typedef struct packed {
		logic sum_ok;
		logic [7:0] sum;
		logic [7:0] cmd1;
		logic [7:0] cmd2;
		logic [7:0] pan;
		logic [7:0] tilt;
	} ptzd_frame_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} ptzd_q_stat_t;

endpackage

`default_nettype wire

@@ hdl/ptzd_rx_if.sv @@
// Byte input channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface ptzd_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/ptzd_res_if.sv @@
// Decoded event output channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface ptzd_res_if;
	logic valid;
	logic ready;
	logic [2:0] event_res;
	logic [7:0] speed;
	logic [7:0] computed_sum;

	modport source (output valid, output event_res, output speed, output computed_sum,
		input ready);
	modport sink (input valid, input event_res, input speed, input computed_sum,
		output ready);
endinterface

`default_nettype wire

@@ hdl/ptzd_fifo.sv @@
// Small frame queue between the byte front end and the event back end.
`timescale 1ns / 1ps
`default_nettype none

module ptzd_fifo #(
	parameter int Depth = ptzd_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ptzd_pkg::ptzd_frame_t push_frame,
	input wire logic pop,
	output ptzd_pkg::ptzd_frame_t head_frame,
	output ptzd_pkg::ptzd_q_stat_t stat
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	ptzd_pkg::ptzd_frame_t mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign stat.full = (count_q == CNT_W'(Depth));
	assign stat.nonempty = (count_q != '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && stat.nonempty;
	assign head_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/ptzd_front.sv @@
// Front end: tracks frame position, keeps a running checksum and queues full frames.
`timescale 1ns / 1ps
`default_nettype none

module ptzd_front (
	input wire logic clk,
	input wire logic arst_n,
	ptzd_rx_if.sink rx_ch,
	input wire ptzd_pkg::ptzd_q_stat_t q_stat,
	output logic push,
	output ptzd_pkg::ptzd_frame_t push_frame
);

	logic [ptzd_pkg::POS_W-1:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] cmd1_q;
	logic [7:0] cmd2_q;
	logic [7:0] pan_q;
	logic [7:0] tilt_q;

	logic accept;
	logic is_sync;

	// Only the checksum byte needs room in the queue.
	assign rx_ch.ready = !((pos_q == ptzd_pkg::POS_CHECK) && q_stat.full);
	assign accept = rx_ch.valid && rx_ch.ready;
	assign is_sync = (rx_ch.rx_byte == ptzd_pkg::SYNC_BYTE);
	assign push = accept && !is_sync && (pos_q == ptzd_pkg::POS_CHECK);

	always_comb begin
		push_frame.sum_ok = (sum_q == rx_ch.rx_byte);
		push_frame.sum = sum_q;
		push_frame.cmd1 = cmd1_q;
		push_frame.cmd2 = cmd2_q;
		push_frame.pan = pan_q;
		push_frame.tilt = tilt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= ptzd_pkg::POS_IDLE;
		end else if (accept) begin
			if (is_sync) begin
				pos_q <= ptzd_pkg::POS_ADDR;
			end else if (pos_q == ptzd_pkg::POS_CHECK) begin
				pos_q <= ptzd_pkg::POS_IDLE;
			end else if (pos_q != ptzd_pkg::POS_IDLE) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Frame bytes; the address only seeds the checksum.
	always_ff @(posedge clk) begin
		if (accept && !is_sync) begin
			unique case (pos_q)
				ptzd_pkg::POS_ADDR: begin
					sum_q <= rx_ch.rx_byte;
				end
				ptzd_pkg::POS_CMD1: begin
					cmd1_q <= rx_ch.rx_byte;
					sum_q <= sum_q + rx_ch.rx_byte;
				end
				ptzd_pkg::POS_CMD2: begin
					cmd2_q <= rx_ch.rx_byte;
					sum_q <= sum_q + rx_ch.rx_byte;
				end
				ptzd_pkg::POS_PAN: begin
					pan_q <= rx_ch.rx_byte;
					sum_q <= sum_q + rx_ch.rx_byte;
				end
				ptzd_pkg::POS_TILT: begin
					tilt_q <= rx_ch.rx_byte;
					sum_q <= sum_q + rx_ch.rx_byte;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/ptzd_back.sv @@
// Back end: turns queued frames into events and holds them in the output register.
`timescale 1ns / 1ps
`default_nettype none

module ptzd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire ptzd_pkg::ptzd_q_stat_t q_stat,
	input wire ptzd_pkg::ptzd_frame_t head_frame,
	output logic pop,
	ptzd_res_if.source res_ch
);

	logic keep;
	ptzd_pkg::ptzd_event_t ev;
	logic [7:0] spd;

	logic out_valid_q;
	ptzd_pkg::ptzd_event_t ev_q;
	logic [7:0] spd_q;
	logic [7:0] sum_q;

	// A frame with a good checksum, a nonzero command and no direction bit yields nothing and is dropped.
	always_comb begin
		keep = 1'b1;
		ev = ptzd_pkg::EV_STOP;
		spd = '0;
		if (!head_frame.sum_ok) begin
			ev = ptzd_pkg::EV_ERROR;
		end else if (head_frame.cmd1 == '0 && head_frame.cmd2 == '0) begin
			ev = ptzd_pkg::EV_STOP;
		end else if (head_frame.cmd2[ptzd_pkg::CMD2_RIGHT_BIT]) begin
			ev = ptzd_pkg::EV_RIGHT;
			spd = head_frame.pan;
		end else if (head_frame.cmd2[ptzd_pkg::CMD2_LEFT_BIT]) begin
			ev = ptzd_pkg::EV_LEFT;
			spd = head_frame.pan;
		end else if (head_frame.cmd2[ptzd_pkg::CMD2_UP_BIT]) begin
			ev = ptzd_pkg::EV_UP;
			spd = head_frame.tilt;
		end else if (head_frame.cmd2[ptzd_pkg::CMD2_DOWN_BIT]) begin
			ev = ptzd_pkg::EV_DOWN;
			spd = head_frame.tilt;
		end else begin
			keep = 1'b0;
		end
	end

	assign pop = q_stat.nonempty && (!out_valid_q || res_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= keep;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q <= ev;
			spd_q <= spd;
			sum_q <= head_frame.sum;
		end
	end

	assign res_ch.valid = out_valid_q;
	assign res_ch.event_res = 3'(ev_q);
	assign res_ch.speed = spd_q;
	assign res_ch.computed_sum = sum_q;

endmodule

`default_nettype wire

@@ hdl/ptz_command_frame_decoder.sv @@
// Top level of the PTZ command frame decoder.
//
//   Channel  Dir  Payload                                  Handshake
//   rx_ch    in   rx_byte[7:0]                             valid/ready
//   res_ch   out  event_res[2:0], speed[7:0], computed_sum valid/ready
//
// One byte is taken every cycle unless the input stalls; the running checksum is updated as bytes arrive.
// The event for a kept frame appears after its checksum byte is taken: the frame is first
// written to the queue, then loaded into the output register once that register is free.
// The input stalls only on a checksum byte while the frame queue is full.
// Reset clears the frame position, the queue pointers and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module ptz_command_frame_decoder #(
	parameter int QueueDepth = ptzd_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	ptzd_rx_if.sink rx_ch,
	ptzd_res_if.source res_ch
);

	logic push;
	logic pop;
	ptzd_pkg::ptzd_frame_t push_frame;
	ptzd_pkg::ptzd_frame_t head_frame;
	ptzd_pkg::ptzd_q_stat_t q_stat;

	ptzd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx_ch(rx_ch),
		.q_stat(q_stat),
		.push(push),
		.push_frame(push_frame)
	);

	ptzd_fifo #(
		.Depth(QueueDepth)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_frame(push_frame),
		.pop(pop),
		.head_frame(head_frame),
		.stat(q_stat)
	);

	ptzd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.head_frame(head_frame),
		.pop(pop),
		.res_ch(res_ch)
	);

	// A frame is never offered to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("frame pushed into a full queue");

	// A sync byte starts a new frame, so the next cycle cannot complete one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_ch.valid && rx_ch.ready && rx_ch.rx_byte == ptzd_pkg::SYNC_BYTE) |=> !push)
		else $error("frame completed right after a sync byte");

	// Stop and checksum errors carry no speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && (res_ch.event_res == 3'(ptzd_pkg::EV_STOP)
			|| res_ch.event_res == 3'(ptzd_pkg::EV_ERROR))) |-> res_ch.speed == 8'd0)
		else $error("nonzero speed on stop or error event");

	// Only defined event codes leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> res_ch.event_res <= 3'(ptzd_pkg::EV_ERROR))
		else $error("undefined event code on output");

endmodule

`default_nettype wire
